### rtl/gdc_pkg.sv
// Garage door controller package: shared types, codes and reset constants.
// No dependencies; imported by every module of the controller.
`default_nettype none

package gdc_pkg;

  // Configuration port geometry
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Register reset values
  localparam logic [15:0] OpenTimeoutRst  = 16'd10000;
  localparam logic [15:0] CloseTimeoutRst = 16'd30000;
  localparam logic [15:0] RelayPulseRst   = 16'd500;
  localparam logic        SensorLevelRst  = 1'b0;

  // Register index codes (word address bits [3:2])
  typedef enum logic [1:0] {
    REG_OPEN_TIMEOUT  = 2'd0,
    REG_CLOSE_TIMEOUT = 2'd1,
    REG_RELAY_PULSE   = 2'd2,
    REG_SENSOR_LEVEL  = 2'd3
  } reg_idx_e;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_e;

  // Door state, one-hot
  typedef enum logic [4:0] {
    DOOR_OPEN    = 5'b00001,
    DOOR_CLOSED  = 5'b00010,
    DOOR_OPENING = 5'b00100,
    DOOR_CLOSING = 5'b01000,
    DOOR_STOPPED = 5'b10000
  } door_e;

  // Output codes of the door state
  localparam logic [2:0] DoorCodeOpen    = 3'd0;
  localparam logic [2:0] DoorCodeClosed  = 3'd1;
  localparam logic [2:0] DoorCodeOpening = 3'd2;
  localparam logic [2:0] DoorCodeClosing = 3'd3;
  localparam logic [2:0] DoorCodeStopped = 3'd4;

  // Which relay the running pulse drives
  typedef enum logic [1:0] {
    PULSE_NONE  = 2'd0,
    PULSE_OPEN  = 2'd1,
    PULSE_STOP  = 2'd2,
    PULSE_CLOSE = 2'd3
  } pulse_e;

  // Configuration seen by the core
  typedef struct packed {
    logic [15:0] open_timeout;
    logic [15:0] close_timeout;
    logic [15:0] relay_pulse;
    logic        active_level;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       timeout_running;
    logic       close_relay_n;
    logic       stop_relay_n;
    logic       open_relay_n;
    logic       target_state;
    logic [2:0] door_state;
  } result_t;

  // Map the one-hot door state to its output code
  function automatic logic [2:0] door_code(input door_e door);
    logic [2:0] code;
    case (door)
      DOOR_OPEN:    code = DoorCodeOpen;
      DOOR_CLOSED:  code = DoorCodeClosed;
      DOOR_OPENING: code = DoorCodeOpening;
      DOOR_CLOSING: code = DoorCodeClosing;
      DOOR_STOPPED: code = DoorCodeStopped;
      default:      code = DoorCodeClosed;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/gdc_apb_regs.sv
// Garage door controller configuration registers behind an APB-style port.
// Depends on gdc_pkg for register codes, reset values and cfg_t.
`default_nettype none

module gdc_apb_regs import gdc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_OPEN_TIMEOUT:  cfg_d.open_timeout  = pwdata[15:0];
        REG_CLOSE_TIMEOUT: cfg_d.close_timeout = pwdata[15:0];
        REG_RELAY_PULSE:   cfg_d.relay_pulse   = pwdata[15:0];
        REG_SENSOR_LEVEL:  cfg_d.active_level  = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_timeout  <= OpenTimeoutRst;
      cfg_q.close_timeout <= CloseTimeoutRst;
      cfg_q.relay_pulse   <= RelayPulseRst;
      cfg_q.active_level  <= SensorLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_OPEN_TIMEOUT:  prdata = {16'd0, cfg_q.open_timeout};
      REG_CLOSE_TIMEOUT: prdata = {16'd0, cfg_q.close_timeout};
      REG_RELAY_PULSE:   prdata = {16'd0, cfg_q.relay_pulse};
      REG_SENSOR_LEVEL:  prdata = {31'd0, cfg_q.active_level};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/gdc_core.sv
// Garage door controller core: door state, operation timeout, relay pulses.
// Depends on gdc_pkg; state advances by one item on each step strobe.
`default_nettype none

module gdc_core import gdc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] mode_i,
  input  wire logic       sensor_enable_i,
  input  wire logic       close_sensor_level_i,
  input  cfg_t            cfg_i,
  output result_t         result_o
);

  localparam logic [63:0] CntMax = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  // Clamp a register value into the counter range, zero counts as one
  function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [15:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    if (ext == 64'd0) ext = 64'd1;
    if (ext > CntMax) ext = CntMax;
    return ext[COUNT_WIDTH-1:0];
  endfunction

  door_e                  door_q, door_d;
  logic                   goal_q, goal_d;
  logic [COUNT_WIDTH-1:0] to_left_q, to_left_d;
  logic                   to_act_q, to_act_d;
  logic                   to_close_q, to_close_d;
  logic                   seen_q, seen_d;
  logic [COUNT_WIDTH-1:0] pls_left_q, pls_left_d;
  pulse_e                 pls_which_q, pls_which_d;
  logic                   closed_now;
  mode_e                  mode;

  assign mode       = mode_e'(mode_i);
  assign closed_now = sensor_enable_i & (close_sensor_level_i == cfg_i.active_level);

  // Next state for one item
  always_comb begin
    door_d      = door_q;
    goal_d      = goal_q;
    to_left_d   = to_left_q;
    to_act_d    = to_act_q;
    to_close_d  = to_close_q;
    seen_d      = seen_q;
    pls_left_d  = pls_left_q;
    pls_which_d = pls_which_q;
    case (mode)
      MODE_TICK: begin
        // relay pulse countdown
        if (pls_left_q != '0) begin
          pls_left_d = pls_left_q - CntOne;
          if (pls_left_q == CntOne) pls_which_d = PULSE_NONE;
        end
        // close sensor edges override the door state
        if (sensor_enable_i && (closed_now != seen_q)) begin
          if (closed_now) begin
            if (door_q == DOOR_CLOSING) begin
              to_act_d  = 1'b0;
              to_left_d = '0;
            end
            door_d = DOOR_CLOSED;
            goal_d = 1'b1;
          end else begin
            if (door_q == DOOR_OPENING) begin
              to_act_d  = 1'b0;
              to_left_d = '0;
            end
            door_d = DOOR_OPEN;
            goal_d = 1'b0;
          end
          seen_d = closed_now;
        end
        // operation timeout
        if (to_act_d) begin
          if (to_left_d != '0) to_left_d = to_left_d - CntOne;
          if (to_left_d == '0) begin
            to_act_d = 1'b0;
            if (to_close_q) begin
              door_d = (!sensor_enable_i || closed_now) ? DOOR_CLOSED : DOOR_STOPPED;
            end else begin
              door_d = DOOR_OPEN;
            end
          end
        end
      end
      MODE_OPEN: begin
        goal_d = 1'b0;
        if ((door_q != DOOR_OPEN) && (door_q != DOOR_OPENING)) begin
          door_d      = DOOR_OPENING;
          pls_which_d = PULSE_OPEN;
          pls_left_d  = load_count(cfg_i.relay_pulse);
          to_close_d  = 1'b0;
          to_left_d   = load_count(cfg_i.open_timeout);
          to_act_d    = 1'b1;
        end
      end
      MODE_STOP: begin
        if ((door_q == DOOR_OPENING) || (door_q == DOOR_CLOSING)) begin
          door_d      = DOOR_STOPPED;
          pls_which_d = PULSE_STOP;
          pls_left_d  = load_count(cfg_i.relay_pulse);
          to_act_d    = 1'b0;
          to_left_d   = '0;
        end
      end
      MODE_CLOSE: begin
        goal_d = 1'b1;
        if ((door_q != DOOR_CLOSED) && (door_q != DOOR_CLOSING)) begin
          door_d      = DOOR_CLOSING;
          pls_which_d = PULSE_CLOSE;
          pls_left_d  = load_count(cfg_i.relay_pulse);
          to_close_d  = 1'b1;
          to_left_d   = load_count(cfg_i.close_timeout);
          to_act_d    = 1'b1;
        end
      end
      default: begin
        door_d = door_q;
      end
    endcase
  end

  // State registers advance once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q      <= DOOR_CLOSED;
      goal_q      <= 1'b1;
      to_left_q   <= '0;
      to_act_q    <= 1'b0;
      to_close_q  <= 1'b0;
      seen_q      <= 1'b0;
      pls_left_q  <= '0;
      pls_which_q <= PULSE_NONE;
    end else if (step_i) begin
      door_q      <= door_d;
      goal_q      <= goal_d;
      to_left_q   <= to_left_d;
      to_act_q    <= to_act_d;
      to_close_q  <= to_close_d;
      seen_q      <= seen_d;
      pls_left_q  <= pls_left_d;
      pls_which_q <= pls_which_d;
    end
  end

  // Result from the updated state
  always_comb begin
    result_o.door_state      = door_code(door_d);
    result_o.target_state    = goal_d;
    result_o.open_relay_n    = !((pls_left_d != '0) && (pls_which_d == PULSE_OPEN));
    result_o.stop_relay_n    = !((pls_left_d != '0) && (pls_which_d == PULSE_STOP));
    result_o.close_relay_n   = !((pls_left_d != '0) && (pls_which_d == PULSE_CLOSE));
    result_o.timeout_running = to_act_d;
  end

endmodule

`default_nettype wire

### rtl/garage_door_controller_top.sv
// Garage door controller top level: input register, core and result register.
// Each item passes the input register, then the core into the result register.
// Throughput: one item per cycle while the receiver is ready; the state
// update is one registered pass.
// Reset (rst_ni, async, active low): door closed, target closed, relays
// released, no timeout, registers at their defaults. Depends on gdc_pkg.
`default_nettype none

module garage_door_controller_top import gdc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // [0] sensor_enable, [1] close_sensor_level
  input  wire logic [1:0]           s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [2:0] door_state, [3] target_state,
                                                   // [4] open_relay_n, [5] stop_relay_n,
                                                   // [6] close_relay_n, [7] timeout_running
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  cfg_t       cfg;
  result_t    result;
  logic       in_valid_q, in_valid_d;
  logic [1:0] mode_q;
  logic       sen_en_q;
  logic       level_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_data_q;
  logic       out_free;
  logic       step;
  logic       in_xfer;

  gdc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: item moves from input register to result register on step
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer)   in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (step)               out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= s_axis_tuser;
      sen_en_q <= s_axis_tdata[0];
      level_q  <= s_axis_tdata[1];
    end
  end

  gdc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (step),
    .mode_i               (mode_q),
    .sensor_enable_i      (sen_en_q),
    .close_sensor_level_i (level_q),
    .cfg_i                (cfg),
    .result_o             (result)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) out_data_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### tb/garage_door_controller_top_tb.sv
// Testbench for garage_door_controller_top: drives ticks and commands on the input
// stream, predicts each status transfer in a local model of the door logic and
// checks it field by field. Depends on gdc_pkg and garage_door_controller_top.
`timescale 1ns / 100ps

module garage_door_controller_top_tb;
  import gdc_pkg::*;

  localparam int unsigned HoldCycles   = 150;   // long receiver hold-off
  localparam int unsigned StuckLimit   = 2000;  // cycles without any transfer
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseItems   = 220;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned NumRows      = 20;

  // One row of the directed table
  typedef struct packed {
    mode_e      mode;
    logic       en;
    logic       lvl;
    logic       typed;
    logic [7:0] want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;  // [0] sensor_enable, [1] close_sensor_level
  logic [1:0]           s_axis_tuser;  // [1:0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;  // [2:0] door_state, [3] target_state,
                                       // [4] open_relay_n, [5] stop_relay_n,
                                       // [6] close_relay_n, [7] timeout_running
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // Local copy of the controller state and its registers
  cfg_t        cfg_shadow;
  logic [2:0]  door_now;
  logic        door_goal;
  logic [15:0] tmo_left;
  logic        tmo_active;
  logic        tmo_for_close;
  logic        closed_seen;
  logic [15:0] pulse_left;
  pulse_e      pulse_kind;

  result_t     status_due[$];  // predicted status transfers, oldest first
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned stall_left;
  logic        quiet;          // no idling on either side while set
  logic        cur_typed;
  logic [7:0]  cur_want;

  // Directed table: typed results only where they follow at a glance
  stim_row_t dir_rows [0:NumRows-1] = '{
    '{MODE_TICK,  1'b0, 1'b0, 1'b1, 8'h79},  // after reset: closed, idle
    '{MODE_STOP,  1'b0, 1'b0, 1'b1, 8'h79},  // stop while idle does nothing
    '{MODE_CLOSE, 1'b0, 1'b0, 1'b1, 8'h79},  // close while closed
    '{MODE_OPEN,  1'b0, 1'b0, 1'b1, 8'hE2},  // opening, open pulse, timeout
    '{MODE_OPEN,  1'b0, 1'b0, 1'b1, 8'hE2},  // open while opening
    '{MODE_STOP,  1'b0, 1'b0, 1'b1, 8'h54},  // stopped, stop pulse replaces
    '{MODE_CLOSE, 1'b0, 1'b0, 1'b1, 8'hBB},  // closing, close pulse
    '{MODE_TICK,  1'b1, 1'b0, 1'b1, 8'h39},  // sensor reads closed
    '{MODE_TICK,  1'b1, 1'b1, 1'b1, 8'h30},  // sensor reads not closed
    '{MODE_TICK,  1'b0, 1'b1, 1'b1, 8'h30},  // sensor disabled
    '{MODE_CLOSE, 1'b1, 1'b1, 1'b0, 8'h00},
    '{MODE_TICK,  1'b1, 1'b1, 1'b0, 8'h00},
    '{MODE_TICK,  1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_OPEN,  1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_STOP,  1'b1, 1'b1, 1'b0, 8'h00},
    '{MODE_OPEN,  1'b0, 1'b1, 1'b0, 8'h00},
    '{MODE_CLOSE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{MODE_STOP,  1'b0, 1'b0, 1'b0, 8'h00},
    '{MODE_TICK,  1'b0, 1'b1, 1'b0, 8'h00},
    '{MODE_CLOSE, 1'b1, 1'b0, 1'b0, 8'h00}
  };

  garage_door_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A zero length counts as one tick
  function automatic logic [15:0] span_of(input logic [15:0] len);
    return (len == '0) ? 16'd1 : len;
  endfunction

  // Advance the door model by one input item and return its status
  function automatic result_t door_step(input mode_e mode, input logic en, input logic lvl);
    logic    closed_now;
    result_t r;
    closed_now = en && (lvl == cfg_shadow.active_level);
    case (mode)
      MODE_TICK: begin
        if (pulse_left != '0) begin
          pulse_left--;
          if (pulse_left == '0) pulse_kind = PULSE_NONE;
        end
        // sensor edges override the door state
        if (en && closed_now != closed_seen) begin
          if (closed_now) begin
            if (door_now == DoorCodeClosing) begin
              tmo_active = 1'b0;
              tmo_left   = '0;
            end
            door_now  = DoorCodeClosed;
            door_goal = 1'b1;
          end else begin
            if (door_now == DoorCodeOpening) begin
              tmo_active = 1'b0;
              tmo_left   = '0;
            end
            door_now  = DoorCodeOpen;
            door_goal = 1'b0;
          end
          closed_seen = closed_now;
        end
        // one-shot operation timeout
        if (tmo_active) begin
          if (tmo_left != '0) tmo_left--;
          if (tmo_left == '0) begin
            tmo_active = 1'b0;
            if (!tmo_for_close) door_now = DoorCodeOpen;
            else if (!en || closed_now) door_now = DoorCodeClosed;
            else door_now = DoorCodeStopped;
          end
        end
      end
      MODE_OPEN: begin
        door_goal = 1'b0;
        if (door_now != DoorCodeOpen && door_now != DoorCodeOpening) begin
          door_now      = DoorCodeOpening;
          pulse_kind    = PULSE_OPEN;
          pulse_left    = span_of(cfg_shadow.relay_pulse);
          tmo_for_close = 1'b0;
          tmo_left      = span_of(cfg_shadow.open_timeout);
          tmo_active    = 1'b1;
        end
      end
      MODE_STOP: begin
        if (door_now == DoorCodeOpening || door_now == DoorCodeClosing) begin
          door_now   = DoorCodeStopped;
          pulse_kind = PULSE_STOP;
          pulse_left = span_of(cfg_shadow.relay_pulse);
          tmo_active = 1'b0;
          tmo_left   = '0;
        end
      end
      default: begin
        door_goal = 1'b1;
        if (door_now != DoorCodeClosed && door_now != DoorCodeClosing) begin
          door_now      = DoorCodeClosing;
          pulse_kind    = PULSE_CLOSE;
          pulse_left    = span_of(cfg_shadow.relay_pulse);
          tmo_for_close = 1'b1;
          tmo_left      = span_of(cfg_shadow.close_timeout);
          tmo_active    = 1'b1;
        end
      end
    endcase
    r.door_state      = door_now;
    r.target_state    = door_goal;
    r.open_relay_n    = !(pulse_left != '0 && pulse_kind == PULSE_OPEN);
    r.stop_relay_n    = !(pulse_left != '0 && pulse_kind == PULSE_STOP);
    r.close_relay_n   = !(pulse_left != '0 && pulse_kind == PULSE_CLOSE);
    r.timeout_running = tmo_active;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Predict on every input transfer
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r = door_step(mode_e'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1]);
      status_due.push_back(cur_typed ? result_t'(cur_want) : r);
    end
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, got %02h", $time, m_axis_tdata);
      end else begin
        want = status_due.pop_front();
        check_field("door_state", want.door_state, got.door_state);
        check_field("target_state", want.target_state, got.target_state);
        check_field("open_relay_n", want.open_relay_n, got.open_relay_n);
        check_field("stop_relay_n", want.stop_relay_n, got.stop_relay_n);
        check_field("close_relay_n", want.close_relay_n, got.close_relay_n);
        check_field("timeout_running", want.timeout_running, got.timeout_running);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    holds_done    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (hold_reqs != holds_done) begin
        holds_done++;
        m_axis_tready = 1'b0;
        stall_left    = HoldCycles - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall_left    = pick_gap();
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one item after an optional gap and hold it until the transfer
  task automatic send_item(input mode_e mode, input logic en, input logic lvl,
                           input logic typed, input logic [7:0] want);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {6'b0, lvl, en};
    cur_typed     = typed;
    cur_want      = want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted status has arrived
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_OPEN_TIMEOUT:  cfg_shadow.open_timeout  = value[15:0];
      REG_CLOSE_TIMEOUT: cfg_shadow.close_timeout = value[15:0];
      REG_RELAY_PULSE:   cfg_shadow.relay_pulse   = value[15:0];
      default:           cfg_shadow.active_level  = value[0];
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random traffic: sticky sensor levels, mostly ticks between commands
  task automatic run_phase(input int unsigned n);
    int unsigned r;
    logic        en;
    logic        lvl;
    mode_e       mode;
    en  = $urandom_range(0, 1);
    lvl = $urandom_range(0, 1);
    for (int unsigned i = 0; i < n; i++) begin
      quiet = ((i / 60) % 3) == 2;
      if (i == n / 4) hold_reqs++;
      if ($urandom_range(0, 19) == 0) lvl = ~lvl;
      if ($urandom_range(0, 39) == 0) en = ~en;
      r = $urandom_range(0, 99);
      if (r < 65) mode = MODE_TICK;
      else if (r < 77) mode = MODE_OPEN;
      else if (r < 87) mode = MODE_STOP;
      else mode = MODE_CLOSE;
      send_item(mode, en, lvl, 1'b0, 8'h00);
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [31:0] setting [4];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_TICK;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet         = 1'b0;
    hold_reqs     = 0;
    mismatches    = 0;
    stuck_cycles  = 0;
    cur_typed     = 1'b0;
    cur_want      = '0;
    cfg_shadow    = '{OpenTimeoutRst, CloseTimeoutRst, RelayPulseRst, SensorLevelRst};
    door_now      = DoorCodeClosed;
    door_goal     = 1'b1;
    tmo_left      = '0;
    tmo_active    = 1'b0;
    tmo_for_close = 1'b0;
    closed_seen   = 1'b0;
    pulse_left    = '0;
    pulse_kind    = PULSE_NONE;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings
    for (int unsigned i = 0; i < NumRows; i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].en, dir_rows[i].lvl,
                dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    // Random phases, each under its own register setting
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: setting = '{32'd1, 32'd1, 32'd1, 32'd1};
        1: setting = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        2: setting = '{32'd0, 32'd0, 32'd0, 32'd0};
        3: setting = '{32'd8, 32'd20, 32'd3, 32'd1};
        default: begin
          setting[0] = $urandom_range(1, 40);
          setting[1] = $urandom_range(1, 40);
          setting[2] = $urandom_range(1, 12);
          setting[3] = $urandom_range(0, 1);
        end
      endcase
      reg_write(REG_OPEN_TIMEOUT, setting[0]);
      reg_write(REG_CLOSE_TIMEOUT, setting[1]);
      reg_write(REG_RELAY_PULSE, setting[2]);
      reg_write(REG_SENSOR_LEVEL, setting[3]);
      run_phase(PhaseItems);
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
